// ===== src/rtcat_pkg.sv =====
`default_nettype none
package rtcat_pkg;

	// Item opcodes
	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	// Register indexes
	localparam int unsigned NUM_REGS = 17;
	localparam logic [4:0] REG_RTCCON  = 5'd0;
	localparam logic [4:0] REG_TICNT   = 5'd1;
	localparam logic [4:0] REG_RTCALM  = 5'd2;
	localparam logic [4:0] REG_ALMSEC  = 5'd3;
	localparam logic [4:0] REG_ALMDATE = 5'd6;
	localparam logic [4:0] REG_ALMMON  = 5'd7;
	localparam logic [4:0] REG_BCDSEC  = 5'd10;
	localparam logic [4:0] REG_BCDMIN  = 5'd11;
	localparam logic [4:0] REG_BCDHOUR = 5'd12;
	localparam logic [4:0] REG_BCDDATE = 5'd13;
	localparam logic [4:0] REG_BCDDAY  = 5'd14;
	localparam logic [4:0] REG_BCDMON  = 5'd15;
	localparam logic [4:0] REG_BCDYEAR = 5'd16;

	// Register bits
	localparam int unsigned TICK_ENABLE_BIT  = 7;
	localparam int unsigned ALARM_ENABLE_BIT = 6;
	localparam int unsigned NUM_ALARM_FIELDS = 6;
	localparam logic [7:0] INVALID_READ = 8'hff;

	typedef struct packed {
		logic [1:0] op;
		logic [4:0] reg_index;
		logic [7:0] write_data;
		logic [5:0] time_second;
		logic [5:0] time_minute;
		logic [4:0] time_hour;
		logic [4:0] time_day;
		logic [2:0] time_weekday;
		logic [3:0] time_month;
		logic [6:0] time_year;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       invalid_index;
		logic       tick_irq;
		logic       alarm_irq;
	} result_t;

	// Binary (0..99, 7-bit input) to two BCD digits; tens digit via reciprocal multiply
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens_x10;
		logic [6:0]  ones;
		prod     = 15'(v) * 15'd205;
		tens     = prod[14:11];
		tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		ones     = v - tens_x10;
		return {tens, ones[3:0]};
	endfunction

	// BCD byte to binary, no digit range check
	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
	endfunction

	// Year modulo 100 for a 7-bit value
	function automatic logic [6:0] year_mod(input logic [6:0] v);
		return (v >= 7'd100) ? v - 7'd100 : v;
	endfunction

endpackage
`default_nettype wire

// ===== src/rtcat_req_if.sv =====
`default_nettype none
interface rtcat_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [4:0] reg_index;
	logic [7:0] write_data;
	logic [5:0] time_second;
	logic [5:0] time_minute;
	logic [4:0] time_hour;
	logic [4:0] time_day;
	logic [2:0] time_weekday;
	logic [3:0] time_month;
	logic [6:0] time_year;

	modport source (output valid, op, reg_index, write_data, time_second, time_minute,
		time_hour, time_day, time_weekday, time_month, time_year, input ready);
	modport sink (input valid, op, reg_index, write_data, time_second, time_minute,
		time_hour, time_day, time_weekday, time_month, time_year, output ready);
endinterface
`default_nettype wire

// ===== src/rtcat_rsp_if.sv =====
`default_nettype none
interface rtcat_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       invalid_index;
	logic       tick_irq;
	logic       alarm_irq;

	modport source (output valid, read_data, invalid_index, tick_irq, alarm_irq,
		input ready);
	modport sink (input valid, read_data, invalid_index, tick_irq, alarm_irq,
		output ready);
endinterface
`default_nettype wire

// ===== src/rtc_alarm_tick_registers.sv =====
// RTC register block with BCD calendar readout, alarm and periodic tick.
// req channel: one item per handshake (op, reg_index, write_data, and the
// binary calendar fields used by a time update).
// rsp channel: exactly one result item per request item, in order, with
// read_data, invalid_index, tick_irq and alarm_irq.
// Path: an accepted item is held in an input register and processed there;
// its result is captured in the output register, whose flag drives rsp.valid.
// Throughput: one item per cycle while rsp is not stalled; the register
// bank and tick countdown update as the item leaves the input register.
// Stall: while rsp.ready is low the result holds; one more item is taken
// into the input register, then req.ready drops until rsp drains.
// Reset (arst_n low): registers clear, alarm date and month read 1, the
// latest time and tick countdown are zero, and both stages empty.
`default_nettype none
module rtc_alarm_tick_registers (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rtcat_req_if.sink  req,
	rtcat_rsp_if.source rsp
);
	import rtcat_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    out_free;
	logic    advance;

	assign out_free  = !valid_s2 || rsp.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.op           <= req.op;
			item_s1.reg_index    <= req.reg_index;
			item_s1.write_data   <= req.write_data;
			item_s1.time_second  <= req.time_second;
			item_s1.time_minute  <= req.time_minute;
			item_s1.time_hour    <= req.time_hour;
			item_s1.time_day     <= req.time_day;
			item_s1.time_weekday <= req.time_weekday;
			item_s1.time_month   <= req.time_month;
			item_s1.time_year    <= req.time_year;
		end
	end

	rtcat_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.read_data     = result_s2.read_data;
	assign rsp.invalid_index = result_s2.invalid_index;
	assign rsp.tick_irq      = result_s2.tick_irq;
	assign rsp.alarm_irq     = result_s2.alarm_irq;
endmodule
`default_nettype wire

// ===== src/rtcat_alarm_cmp.sv =====
`default_nettype none
module rtcat_alarm_cmp (
	input  wire logic [5:0][7:0] now,
	input  wire logic [5:0][7:0] alarm_bcd,
	input  wire logic [5:0]      sel,
	output logic                 match
);
	import rtcat_pkg::*;

	logic [5:0] field_ok;

	// A field passes when unselected or equal to its decoded alarm value
	always_comb begin
		for (int k = 0; k < NUM_ALARM_FIELDS; k++) begin
			field_ok[k] = !sel[k] || (now[k] == from_bcd(alarm_bcd[k]));
		end
	end

	assign match = &field_ok;
endmodule
`default_nettype wire

// ===== src/rtcat_core.sv =====
`default_nettype none
module rtcat_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire rtcat_pkg::item_t  item,
	output rtcat_pkg::result_t     result
);
	import rtcat_pkg::*;

	logic [7:0] bank_q [NUM_REGS];
	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic [4:0] day_q;
	logic [2:0] wday_q;
	logic [3:0] mon_q;
	logic [6:0] year_q;
	logic [7:0] countdown_q;

	logic       idx_ok;
	logic [3:0] wday_plus;
	logic [7:0] cal_data;
	logic [7:0] reload;
	logic       tick_en;
	logic       tick_hit;
	logic [5:0][7:0] now;
	logic [5:0][7:0] alarm_bcd;
	logic       alarm_match;

	assign idx_ok    = item.reg_index < 5'(NUM_REGS);
	assign wday_plus = {1'b0, wday_q} + 4'd1;
	assign reload    = {1'b0, bank_q[REG_TICNT][6:0]} + 8'd1;
	assign tick_en   = bank_q[REG_TICNT][TICK_ENABLE_BIT];
	assign tick_hit  = countdown_q <= 8'd1;

	// Calendar register read in BCD
	always_comb begin
		unique case (item.reg_index)
			REG_BCDSEC:  cal_data = to_bcd({1'b0, sec_q});
			REG_BCDMIN:  cal_data = to_bcd({1'b0, min_q});
			REG_BCDHOUR: cal_data = to_bcd({2'b0, hour_q});
			REG_BCDDATE: cal_data = to_bcd({2'b0, day_q});
			REG_BCDDAY:  cal_data = to_bcd({3'b0, wday_plus});
			REG_BCDMON:  cal_data = to_bcd({3'b0, mon_q});
			default:     cal_data = to_bcd(year_mod(year_q));
		endcase
	end

	// Alarm compare uses the incoming time
	always_comb begin
		now[0] = {2'b0, item.time_second};
		now[1] = {2'b0, item.time_minute};
		now[2] = {3'b0, item.time_hour};
		now[3] = {3'b0, item.time_day};
		now[4] = {4'b0, item.time_month};
		now[5] = {1'b0, year_mod(item.time_year)};
		for (int k = 0; k < NUM_ALARM_FIELDS; k++) begin
			alarm_bcd[k] = bank_q[REG_ALMSEC + 5'(k)];
		end
	end

	rtcat_alarm_cmp u_alarm_cmp (
		.now       (now),
		.alarm_bcd (alarm_bcd),
		.sel       (bank_q[REG_RTCALM][5:0]),
		.match     (alarm_match)
	);

	// Result of the current item
	always_comb begin
		result = '0;
		unique case (item.op)
			OP_READ: begin
				if (!idx_ok) begin
					result.read_data     = INVALID_READ;
					result.invalid_index = 1'b1;
				end else if (item.reg_index >= REG_BCDSEC) begin
					result.read_data = cal_data;
				end else begin
					result.read_data = bank_q[item.reg_index];
				end
			end
			OP_WRITE: result.invalid_index = !idx_ok;
			OP_UPDATE: result.alarm_irq =
				bank_q[REG_RTCALM][ALARM_ENABLE_BIT] && alarm_match;
			default: result.tick_irq = tick_en && tick_hit;
		endcase
	end

	// Register bank and tick countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				bank_q[i] <= 8'd0;
			end
			bank_q[REG_ALMDATE] <= 8'd1;
			bank_q[REG_ALMMON]  <= 8'd1;
			countdown_q <= 8'd0;
		end else if (fire) begin
			if (item.op == OP_WRITE && idx_ok) begin
				bank_q[item.reg_index] <= item.write_data;
				if (item.reg_index == REG_TICNT) begin
					countdown_q <= {1'b0, item.write_data[6:0]} + 8'd1;
				end
			end else if (item.op == OP_TICK && tick_en) begin
				countdown_q <= tick_hit ? reload : countdown_q - 8'd1;
			end
		end
	end

	// Latest time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			min_q  <= '0;
			hour_q <= '0;
			day_q  <= '0;
			wday_q <= '0;
			mon_q  <= '0;
			year_q <= '0;
		end else if (fire && item.op == OP_UPDATE) begin
			sec_q  <= item.time_second;
			min_q  <= item.time_minute;
			hour_q <= item.time_hour;
			day_q  <= item.time_day;
			wday_q <= item.time_weekday;
			mon_q  <= item.time_month;
			year_q <= item.time_year;
		end
	end
endmodule
`default_nettype wire
